>>> hw/rtl/chc_pkg.sv
// Package with the header positions, the logo table and the code decoders of the header checker.
package chc_pkg;

    localparam int unsigned POS_BITS = 9;

    localparam logic [POS_BITS-1:0] LOGO_FIRST  = 9'h104;
    localparam logic [POS_BITS-1:0] LOGO_LAST   = 9'h133;
    localparam logic [POS_BITS-1:0] HDR_FIRST   = 9'h134;
    localparam logic [POS_BITS-1:0] HDR_LAST    = 9'h14C;
    localparam logic [POS_BITS-1:0] HDR_SUM_POS = 9'h14D;
    localparam logic [POS_BITS-1:0] GSUM_HI_POS = 9'h14E;
    localparam logic [POS_BITS-1:0] GSUM_LO_POS = 9'h14F;
    localparam logic [POS_BITS-1:0] MODE_POS    = 9'h143;
    localparam logic [POS_BITS-1:0] KIND_POS    = 9'h147;
    localparam logic [POS_BITS-1:0] SIZE_POS    = 9'h148;

    localparam logic [7:0] MODE_CODE_DUAL   = 8'h80;
    localparam logic [7:0] MODE_CODE_COLOUR = 8'hC0;

    localparam logic [1:0] MODE_DUAL     = 2'd0;
    localparam logic [1:0] MODE_COLOUR   = 2'd1;
    localparam logic [1:0] MODE_ORIGINAL = 2'd2;

    localparam logic [4:0] KIND_UNKNOWN = 5'd26;

    function automatic logic [7:0] logo_byte(input logic [5:0] idx);
        logic [7:0] v;
        case (idx)
            6'd0:  v = 8'hCE;  6'd1:  v = 8'hED;  6'd2:  v = 8'h66;  6'd3:  v = 8'h66;
            6'd4:  v = 8'hCC;  6'd5:  v = 8'h0D;  6'd6:  v = 8'h00;  6'd7:  v = 8'h0B;
            6'd8:  v = 8'h03;  6'd9:  v = 8'h73;  6'd10: v = 8'h00;  6'd11: v = 8'h83;
            6'd12: v = 8'h00;  6'd13: v = 8'h0C;  6'd14: v = 8'h00;  6'd15: v = 8'h0D;
            6'd16: v = 8'h00;  6'd17: v = 8'h08;  6'd18: v = 8'h11;  6'd19: v = 8'h1F;
            6'd20: v = 8'h88;  6'd21: v = 8'h89;  6'd22: v = 8'h00;  6'd23: v = 8'h0E;
            6'd24: v = 8'hDC;  6'd25: v = 8'hCC;  6'd26: v = 8'h6E;  6'd27: v = 8'hE6;
            6'd28: v = 8'hDD;  6'd29: v = 8'hDD;  6'd30: v = 8'hD9;  6'd31: v = 8'h99;
            6'd32: v = 8'hBB;  6'd33: v = 8'hBB;  6'd34: v = 8'h67;  6'd35: v = 8'h63;
            6'd36: v = 8'h6E;  6'd37: v = 8'h0E;  6'd38: v = 8'hEC;  6'd39: v = 8'hCC;
            6'd40: v = 8'hDD;  6'd41: v = 8'hDC;  6'd42: v = 8'h99;  6'd43: v = 8'h9F;
            6'd44: v = 8'hBB;  6'd45: v = 8'hB9;  6'd46: v = 8'h33;  6'd47: v = 8'h3E;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] decode_mode(input logic [7:0] code);
        logic [1:0] m;
        if (code == MODE_CODE_DUAL) begin
            m = MODE_DUAL;
        end else if (code == MODE_CODE_COLOUR) begin
            m = MODE_COLOUR;
        end else begin
            m = MODE_ORIGINAL;
        end
        return m;
    endfunction

    function automatic logic [4:0] decode_kind(input logic [7:0] code);
        logic [4:0] k;
        unique case (code)
            8'h00: k = 5'd0;
            8'h01: k = 5'd1;
            8'h02: k = 5'd2;
            8'h03: k = 5'd3;
            8'h05: k = 5'd4;
            8'h06: k = 5'd5;
            8'h08: k = 5'd6;
            8'h09: k = 5'd7;
            8'h0B: k = 5'd8;
            8'h0C: k = 5'd9;
            8'h0D: k = 5'd10;
            8'h0F: k = 5'd11;
            8'h10: k = 5'd12;
            8'h11: k = 5'd13;
            8'h12: k = 5'd14;
            8'h13: k = 5'd15;
            8'h19: k = 5'd16;
            8'h1A: k = 5'd17;
            8'h1B: k = 5'd18;
            8'h1C: k = 5'd19;
            8'h1D: k = 5'd20;
            8'h1E: k = 5'd21;
            8'h1F: k = 5'd22;
            8'hFD: k = 5'd23;
            8'hFE: k = 5'd24;
            8'hFF: k = 5'd25;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [23:0] decode_size(input logic [7:0] code);
        logic [23:0] s;
        unique case (code)
            8'h00: s = 24'h008000;
            8'h01: s = 24'h010000;
            8'h02: s = 24'h020000;
            8'h03: s = 24'h040000;
            8'h04: s = 24'h080000;
            8'h05: s = 24'h100000;
            8'h06: s = 24'h200000;
            8'h07: s = 24'h400000;
            8'h08: s = 24'h800000;
            8'h52: s = 24'd1179648;
            8'h53: s = 24'd1310720;
            8'h54: s = 24'd1572864;
            default: s = 24'h000000;
        endcase
        return s;
    endfunction

endpackage

>>> hw/rtl/cartridge_header_checker.sv
// Streaming cartridge header checker: logo, header checksum, global sum and code decode.
// The block takes one image word per cycle with no gaps of its own; a word sits in an input
// register, where a single update pass over the running checks runs as it advances, and the
// verdict for a word marked last appears on the result channel in the cycle after that. A new
// image may start in the word right after a last word. The only stall comes from a verdict
// that is still waiting for m_ready, and then just the last word of the next image waits.
module cartridge_header_checker #(
    parameter int unsigned ADDRESS_BITS = 23
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rom_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_logo_ok,
    output logic        m_header_sum_ok,
    output logic        m_global_sum_ok,
    output logic [1:0]  m_colour_mode,
    output logic [4:0]  m_cartridge_kind,
    output logic [23:0] m_rom_size_bytes
);

    localparam logic [ADDRESS_BITS-1:0] POS_MAX = {ADDRESS_BITS{1'b1}};

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    in_last_reg;

    logic [ADDRESS_BITS-1:0] pos_reg, pos_next;
    logic                    logo_bad_reg, logo_bad_next;
    logic [7:0]              hdr_acc_reg, hdr_acc_next;
    logic [7:0]              hdr_exp_reg, hdr_exp_next;
    logic [15:0]             gsum_acc_reg, gsum_acc_next;
    logic [15:0]             gsum_exp_reg, gsum_exp_next;
    logic [7:0]              mode_code_reg, mode_code_next;
    logic [7:0]              kind_code_reg, kind_code_next;
    logic [7:0]              size_code_reg, size_code_next;

    logic                    m_valid_reg;
    logic                    logo_ok_reg, hdr_ok_reg, gsum_ok_reg;
    logic [1:0]              mode_reg;
    logic [4:0]              kind_reg;
    logic [23:0]             size_reg;

    logic                    advance;
    logic                    full;
    logic [ADDRESS_BITS-1:0] logo_off;

    assign advance = in_valid_reg && (!in_last_reg || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign logo_off = pos_reg - ADDRESS_BITS'(chc_pkg::LOGO_FIRST);
    assign full     = pos_reg >= ADDRESS_BITS'(chc_pkg::GSUM_LO_POS);

    always_comb begin
        pos_next       = pos_reg;
        logo_bad_next  = logo_bad_reg;
        hdr_acc_next   = hdr_acc_reg;
        hdr_exp_next   = hdr_exp_reg;
        gsum_acc_next  = gsum_acc_reg;
        gsum_exp_next  = gsum_exp_reg;
        mode_code_next = mode_code_reg;
        kind_code_next = kind_code_reg;
        size_code_next = size_code_reg;

        if (pos_reg >= ADDRESS_BITS'(chc_pkg::LOGO_FIRST) &&
            pos_reg <= ADDRESS_BITS'(chc_pkg::LOGO_LAST) &&
            in_byte_reg != chc_pkg::logo_byte(logo_off[5:0])) begin
            logo_bad_next = 1'b1;
        end
        if (pos_reg >= ADDRESS_BITS'(chc_pkg::HDR_FIRST) &&
            pos_reg <= ADDRESS_BITS'(chc_pkg::HDR_LAST)) begin
            hdr_acc_next = hdr_acc_reg - in_byte_reg - 8'd1;
        end
        if (pos_reg == ADDRESS_BITS'(chc_pkg::HDR_SUM_POS)) begin
            hdr_exp_next = in_byte_reg;
        end
        if (pos_reg == ADDRESS_BITS'(chc_pkg::GSUM_HI_POS)) begin
            gsum_exp_next[15:8] = in_byte_reg;
        end else if (pos_reg == ADDRESS_BITS'(chc_pkg::GSUM_LO_POS)) begin
            gsum_exp_next[7:0] = in_byte_reg;
        end else begin
            gsum_acc_next = gsum_acc_reg + {8'h00, in_byte_reg};
        end
        if (pos_reg == ADDRESS_BITS'(chc_pkg::MODE_POS)) begin
            mode_code_next = in_byte_reg;
        end
        if (pos_reg == ADDRESS_BITS'(chc_pkg::KIND_POS)) begin
            kind_code_next = in_byte_reg;
        end
        if (pos_reg == ADDRESS_BITS'(chc_pkg::SIZE_POS)) begin
            size_code_next = in_byte_reg;
        end
        if (pos_reg != POS_MAX) begin
            pos_next = pos_reg + ADDRESS_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rom_byte;
            in_last_reg <= s_last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_last_reg)) begin
            pos_reg       <= '0;
            logo_bad_reg  <= 1'b0;
            hdr_acc_reg   <= 8'h00;
            hdr_exp_reg   <= 8'h00;
            gsum_acc_reg  <= 16'h0000;
            gsum_exp_reg  <= 16'h0000;
            mode_code_reg <= 8'h00;
            kind_code_reg <= 8'h00;
            size_code_reg <= 8'h00;
        end else if (advance) begin
            pos_reg       <= pos_next;
            logo_bad_reg  <= logo_bad_next;
            hdr_acc_reg   <= hdr_acc_next;
            hdr_exp_reg   <= hdr_exp_next;
            gsum_acc_reg  <= gsum_acc_next;
            gsum_exp_reg  <= gsum_exp_next;
            mode_code_reg <= mode_code_next;
            kind_code_reg <= kind_code_next;
            size_code_reg <= size_code_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            logo_ok_reg <= full && !logo_bad_next;
            hdr_ok_reg  <= full && (hdr_acc_next == hdr_exp_next);
            gsum_ok_reg <= full && (gsum_acc_next == gsum_exp_next);
            mode_reg    <= chc_pkg::decode_mode(mode_code_next);
            kind_reg    <= chc_pkg::decode_kind(kind_code_next);
            size_reg    <= chc_pkg::decode_size(size_code_next);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_logo_ok        = logo_ok_reg;
    assign m_header_sum_ok  = hdr_ok_reg;
    assign m_global_sum_ok  = gsum_ok_reg;
    assign m_colour_mode    = mode_reg;
    assign m_cartridge_kind = kind_reg;
    assign m_rom_size_bytes = size_reg;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the cartridge header checker: image streams, verdict prediction.
module tb_top;

    localparam int unsigned ADDR_BITS  = 9;
    localparam int unsigned HEADER_END = 'h150;
    localparam int unsigned LONG_HOLD  = 200;
    localparam int unsigned WORD_COUNT = 1050;

    localparam logic [7:0] SIZE_CODE_72_BANKS = 8'h52;
    localparam logic [7:0] SIZE_CODE_80_BANKS = 8'h53;
    localparam logic [7:0] SIZE_CODE_96_BANKS = 8'h54;
    localparam logic [7:0] SIZE_CODE_LAST_POW = 8'h08;

    localparam logic [48*8-1:0] LOGO_REF = {
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E
    };

    localparam logic [26*8-1:0] KIND_CODES = {
        8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h06, 8'h08, 8'h09, 8'h0B,
        8'h0C, 8'h0D, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 8'h19, 8'h1A,
        8'h1B, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'hFD, 8'hFE, 8'hFF
    };

    localparam logic [16*8-1:0] SIZE_SWEEP = {
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'h08, 8'h52, 8'h53, 8'h54, 8'h09, 8'h51, 8'h55, 8'hFF
    };

    typedef struct packed {
        logic        logo_ok;
        logic        header_sum_ok;
        logic        global_sum_ok;
        logic [1:0]  colour_mode;
        logic [4:0]  cartridge_kind;
        logic [23:0] rom_size_bytes;
    } verdict_t;

    typedef logic [7:0] image_q_t[$];

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rom_byte = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_logo_ok;
    logic        m_header_sum_ok;
    logic        m_global_sum_ok;
    logic [1:0]  m_colour_mode;
    logic [4:0]  m_cartridge_kind;
    logic [23:0] m_rom_size_bytes;

    // Shadow copy of the checker state.
    logic [ADDR_BITS-1:0] shadow_pos = '0;
    logic                 shadow_logo_bad = 1'b0;
    logic [7:0]           shadow_hdr_acc = 8'h00;
    logic [7:0]           shadow_hdr_want = 8'h00;
    logic [15:0]          shadow_sum_acc = 16'h0000;
    logic [15:0]          shadow_sum_want = 16'h0000;
    logic [7:0]           shadow_mode_code = 8'h00;
    logic [7:0]           shadow_kind_code = 8'h00;
    logic [7:0]           shadow_size_code = 8'h00;

    verdict_t    verdict_q[$];
    int unsigned fail_count = 0;
    int unsigned images_sent = 0;
    int unsigned words_sent = 0;

    bit          tx_idle_en = 1'b0;
    int unsigned burst_left = 0;
    bit          rx_stall_en = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned hold_left = 0;
    logic [15:0] stall_bits = 16'hFFFF;
    logic [3:0]  stall_age = 4'd0;

    cartridge_header_checker #(
        .ADDRESS_BITS(ADDR_BITS)
    ) u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rom_byte      (s_rom_byte),
        .s_last_byte     (s_last_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_logo_ok       (m_logo_ok),
        .m_header_sum_ok (m_header_sum_ok),
        .m_global_sum_ok (m_global_sum_ok),
        .m_colour_mode   (m_colour_mode),
        .m_cartridge_kind(m_cartridge_kind),
        .m_rom_size_bytes(m_rom_size_bytes)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #18_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [7:0] logo_at(input int unsigned idx);
        return LOGO_REF[(47 - idx) * 8 +: 8];
    endfunction

    function automatic logic [7:0] kind_code_at(input int unsigned idx);
        return KIND_CODES[(25 - idx) * 8 +: 8];
    endfunction

    function automatic logic [1:0] mode_of_code(input logic [7:0] code);
        if (code == chc_pkg::MODE_CODE_DUAL) begin
            return chc_pkg::MODE_DUAL;
        end else if (code == chc_pkg::MODE_CODE_COLOUR) begin
            return chc_pkg::MODE_COLOUR;
        end
        return chc_pkg::MODE_ORIGINAL;
    endfunction

    function automatic logic [4:0] kind_of_code(input logic [7:0] code);
        for (int k = 0; k < 26; k++) begin
            if (kind_code_at(k) == code) begin
                return k[4:0];
            end
        end
        return chc_pkg::KIND_UNKNOWN;
    endfunction

    function automatic logic [23:0] size_of_code(input logic [7:0] code);
        if (code <= SIZE_CODE_LAST_POW) begin
            return 24'h008000 << code;
        end else if (code == SIZE_CODE_72_BANKS) begin
            return 24'd1179648;
        end else if (code == SIZE_CODE_80_BANKS) begin
            return 24'd1310720;
        end else if (code == SIZE_CODE_96_BANKS) begin
            return 24'd1572864;
        end
        return 24'd0;
    endfunction

    // Advances the shadow state by one accepted word and queues a verdict on the last one.
    task automatic absorb_rom_byte(input logic [7:0] b, input logic last);
        logic [ADDR_BITS-1:0] p;
        verdict_t             v;
        bit                   full;
        p = shadow_pos;
        if (p >= chc_pkg::LOGO_FIRST && p <= chc_pkg::LOGO_LAST &&
            b != logo_at(p - chc_pkg::LOGO_FIRST)) begin
            shadow_logo_bad = 1'b1;
        end
        if (p >= chc_pkg::HDR_FIRST && p <= chc_pkg::HDR_LAST) begin
            shadow_hdr_acc = shadow_hdr_acc - b - 8'd1;
        end
        if (p == chc_pkg::HDR_SUM_POS) begin
            shadow_hdr_want = b;
        end
        if (p == chc_pkg::GSUM_HI_POS) begin
            shadow_sum_want[15:8] = b;
        end else if (p == chc_pkg::GSUM_LO_POS) begin
            shadow_sum_want[7:0] = b;
        end else begin
            shadow_sum_acc = shadow_sum_acc + 16'(b);
        end
        if (p == chc_pkg::MODE_POS) begin
            shadow_mode_code = b;
        end
        if (p == chc_pkg::KIND_POS) begin
            shadow_kind_code = b;
        end
        if (p == chc_pkg::SIZE_POS) begin
            shadow_size_code = b;
        end
        if (p != {ADDR_BITS{1'b1}}) begin
            shadow_pos = p + 1'b1;
        end
        if (last) begin
            full = (int'(p) + 1 >= HEADER_END);
            v.logo_ok        = full && !shadow_logo_bad;
            v.header_sum_ok  = full && (shadow_hdr_acc == shadow_hdr_want);
            v.global_sum_ok  = full && (shadow_sum_acc == shadow_sum_want);
            v.colour_mode    = mode_of_code(shadow_mode_code);
            v.cartridge_kind = kind_of_code(shadow_kind_code);
            v.rom_size_bytes = size_of_code(shadow_size_code);
            verdict_q.push_back(v);
            shadow_pos       = '0;
            shadow_logo_bad  = 1'b0;
            shadow_hdr_acc   = 8'h00;
            shadow_hdr_want  = 8'h00;
            shadow_sum_acc   = 16'h0000;
            shadow_sum_want  = 16'h0000;
            shadow_mode_code = 8'h00;
            shadow_kind_code = 8'h00;
            shadow_size_code = 8'h00;
        end
    endtask

    task automatic send_word(input logic [7:0] b, input logic last);
        if (tx_idle_en) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        s_valid     <= 1'b1;
        s_rom_byte  <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        absorb_rom_byte(b, last);
    endtask

    task automatic send_image(input image_q_t img);
        for (int i = 0; i < img.size(); i++) begin
            send_word(img[i], i == img.size() - 1);
        end
        images_sent++;
    endtask

    // Builds an image of random content; a proper one carries the logo and both checksums.
    function automatic image_q_t make_image(input int unsigned len, input bit proper,
                                            input logic [7:0] mode_c, input logic [7:0] kind_c,
                                            input logic [7:0] size_c);
        image_q_t    img;
        logic [7:0]  hsum;
        logic [15:0] gsum;
        for (int i = 0; i < len; i++) begin
            img.push_back(8'($urandom_range(0, 255)));
        end
        if (chc_pkg::MODE_POS < len) img[chc_pkg::MODE_POS] = mode_c;
        if (chc_pkg::KIND_POS < len) img[chc_pkg::KIND_POS] = kind_c;
        if (chc_pkg::SIZE_POS < len) img[chc_pkg::SIZE_POS] = size_c;
        if (proper) begin
            for (int i = 0; i < 48; i++) begin
                if (chc_pkg::LOGO_FIRST + i < len) img[chc_pkg::LOGO_FIRST + i] = logo_at(i);
            end
            hsum = 8'h00;
            for (int i = chc_pkg::HDR_FIRST; i <= chc_pkg::HDR_LAST && i < len; i++) begin
                hsum = hsum - img[i] - 8'd1;
            end
            if (chc_pkg::HDR_SUM_POS < len) img[chc_pkg::HDR_SUM_POS] = hsum;
            gsum = 16'h0000;
            for (int i = 0; i < len; i++) begin
                if (i != chc_pkg::GSUM_HI_POS && i != chc_pkg::GSUM_LO_POS) begin
                    gsum = gsum + 16'(img[i]);
                end
            end
            if (chc_pkg::GSUM_LO_POS < len) begin
                img[chc_pkg::GSUM_HI_POS] = gsum[15:8];
                img[chc_pkg::GSUM_LO_POS] = gsum[7:0];
            end
        end
        return img;
    endfunction

    function automatic logic [7:0] pick_mode_code();
        case ($urandom_range(0, 2))
            0: return chc_pkg::MODE_CODE_DUAL;
            1: return chc_pkg::MODE_CODE_COLOUR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_kind_code();
        if ($urandom_range(0, 9) < 7) return kind_code_at($urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_size_code();
        if ($urandom_range(0, 9) < 7) return SIZE_SWEEP[(15 - $urandom_range(0, 11)) * 8 +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic test_boundaries();
        image_q_t img;
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        img = {8'h00};
        send_image(img);
        img = {8'hFF};
        send_image(img);
        img = {8'h5A, 8'hA5};
        send_image(img);
        send_image(make_image('h14F, 1'b1, chc_pkg::MODE_CODE_COLOUR, 8'hFF,
                              SIZE_CODE_96_BANKS));
    endtask

    // The image runs past the top position so that the position counter saturates.
    task automatic test_saturation();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        send_image(make_image(520, 1'b1, chc_pkg::MODE_CODE_DUAL, 8'h1F, 8'h05));
    endtask

    task automatic test_backpressure();
        image_q_t img;
        tx_idle_en = 1'b0;
        hold_req   = 1'b1;
        for (int i = 0; i < 8; i++) begin
            img = {8'($urandom_range(0, 255))};
            if (i % 2 == 1) img.push_back(8'($urandom_range(0, 255)));
            send_image(img);
        end
        tx_idle_en = 1'b1;
        hold_req   = 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_image(make_image($urandom_range(1, 4), 1'b0, 8'h00, 8'h00, 8'h00));
        end
    endtask

    task automatic test_random_images();
        image_q_t    img;
        int unsigned len;
        int unsigned idx;
        bit          proper;
        while (words_sent < WORD_COUNT) begin
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0) hold_req = 1'b1;
            proper = ($urandom_range(0, 9) != 0);
            len    = $urandom_range(1, 24);
            img = make_image(len, proper, pick_mode_code(), pick_kind_code(), pick_size_code());
            if ($urandom_range(0, 3) == 0) begin
                idx = $urandom_range(0, len - 1);
                img[idx] = img[idx] ^ 8'($urandom_range(1, 255));
            end
            send_image(img);
        end
    endtask

    // Receiver: a rotating stall pattern, or a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else begin
            stall_age <= stall_age + 4'd1;
            if (stall_age == 4'd0) begin
                stall_bits <= 16'($urandom) | 16'($urandom);
            end else begin
                stall_bits <= {stall_bits[0], stall_bits[15:1]};
            end
            m_ready <= !rx_stall_en || stall_bits[0];
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : verdict_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("verdict word arrived with none outstanding");
                fail_count++;
            end else begin
                want = verdict_q.pop_front();
                check_field("logo_ok", want.logo_ok, m_logo_ok);
                check_field("header_sum_ok", want.header_sum_ok, m_header_sum_ok);
                check_field("global_sum_ok", want.global_sum_ok, m_global_sum_ok);
                check_field("colour_mode", want.colour_mode, m_colour_mode);
                check_field("cartridge_kind", want.cartridge_kind, m_cartridge_kind);
                check_field("rom_size_bytes", want.rom_size_bytes, m_rom_size_bytes);
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_boundaries();
        test_saturation();
        test_backpressure();
        test_random_images();
        s_valid <= 1'b0;
        rx_stall_en = 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/chc_pkg.sv
hw/rtl/cartridge_header_checker.sv
sim/tb_top.sv
